// ----- src/xsa_pkg.sv -----
package xsa_pkg;

   localparam int LANES            = 8;
   localparam int WORD_W           = 64;
   localparam int HALF_W           = 32;
   localparam int MODE_W           = 2;
   localparam int IDX_W            = 5;
   localparam int SECRET_BYTES_DEF = 192;
   localparam int STRIPE_BYTES     = 64;
   localparam int WORD_BYTES       = 8;
   localparam int LASTACC_START    = 7;
   localparam int TAIL_BYTES       = STRIPE_BYTES + LASTACC_START;
   localparam int SHIFT_MIX        = 47;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STRIPE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINAL  = 2'd2;

   localparam logic [HALF_W-1:0] PRIME32_1 = 32'h9E37_79B1;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type ACC_INIT [LANES] = '{
      64'h0000_0000_C2B2_AE3D,
      64'h9E37_79B1_85EB_CA87,
      64'hC2B2_AE3D_27D4_EB4F,
      64'h1656_67B1_9E37_79F9,
      64'h85EB_CA77_C2B2_AE63,
      64'h0000_0000_85EB_CA77,
      64'h27D4_EB2F_1656_67C5,
      64'h0000_0000_9E37_79B1
   };

   typedef struct packed {
      logic valid;
      logic final_item;
      logic scramble;
   } ctl_type;

endpackage

// ----- src/xsa_if.sv -----
interface xsa_req_if;
   logic                         valid;
   logic                         ready;
   logic [xsa_pkg::MODE_W-1:0]   mode;
   logic [xsa_pkg::IDX_W-1:0]    secret_index;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_0;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_1;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_2;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_3;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_4;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_5;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_6;
   logic [xsa_pkg::WORD_W-1:0]   lane_word_7;

   modport source (
      output valid, mode, secret_index,
      output lane_word_0, lane_word_1, lane_word_2, lane_word_3,
      output lane_word_4, lane_word_5, lane_word_6, lane_word_7,
      input  ready
   );
   modport sink (
      input  valid, mode, secret_index,
      input  lane_word_0, lane_word_1, lane_word_2, lane_word_3,
      input  lane_word_4, lane_word_5, lane_word_6, lane_word_7,
      output ready
   );
endinterface

interface xsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_0;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_1;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_2;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_3;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_4;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_5;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_6;
   logic [xsa_pkg::WORD_W-1:0]   acc_out_7;

   modport source (
      output valid,
      output acc_out_0, acc_out_1, acc_out_2, acc_out_3,
      output acc_out_4, acc_out_5, acc_out_6, acc_out_7,
      input  ready
   );
   modport sink (
      input  valid,
      input  acc_out_0, acc_out_1, acc_out_2, acc_out_3,
      input  acc_out_4, acc_out_5, acc_out_6, acc_out_7,
      output ready
   );
endinterface

// ----- src/xsa_lane.sv -----
module xsa_lane #(
   parameter int SECRET_BYTES = xsa_pkg::SECRET_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic                       wr_en,
   input  logic [xsa_pkg::IDX_W-1:0]  wr_addr,
   input  xsa_pkg::word_type          wr_data,
   input  logic [xsa_pkg::IDX_W-1:0]  rd_addr,
   input  logic                       final_sel,
   input  xsa_pkg::word_type          data_own,
   input  xsa_pkg::word_type          data_mate,
   input  xsa_pkg::word_type          final_secret,
   output xsa_pkg::word_type          inc
);

   localparam int NWORDS = SECRET_BYTES / xsa_pkg::WORD_BYTES;
   localparam int AW     = $clog2(NWORDS);
   localparam int HW     = xsa_pkg::HALF_W;
   localparam int WW     = xsa_pkg::WORD_W;

   xsa_pkg::word_type mem [NWORDS];
   xsa_pkg::word_type sec_ff;
   xsa_pkg::word_type own_ff;
   xsa_pkg::word_type mate_ff;
   xsa_pkg::word_type mate_b_ff;
   xsa_pkg::word_type prod_ff;
   xsa_pkg::word_type inc_ff;
   xsa_pkg::word_type key;

   // full copy of the secret per lane, one read port each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sec_ff  <= mem[rd_addr[AW-1:0]];
         own_ff  <= data_own;
         mate_ff <= data_mate;
      end
   end

   assign key = own_ff ^ (final_sel ? final_secret : sec_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= WW'(key[HW-1:0]) * WW'(key[WW-1:HW]);
         mate_b_ff <= mate_ff;
         inc_ff    <= prod_ff + mate_b_ff;
      end
   end

   assign inc = inc_ff;

endmodule

// ----- src/xsa_merge.sv -----
module xsa_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  xsa_pkg::ctl_type   ctl,
   input  xsa_pkg::word_type  inc        [xsa_pkg::LANES],
   input  xsa_pkg::word_type  scr_secret [xsa_pkg::LANES],
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output xsa_pkg::word_type  acc_out    [xsa_pkg::LANES]
);

   localparam int LN = xsa_pkg::LANES;
   localparam int HW = xsa_pkg::HALF_W;
   localparam int WW = xsa_pkg::WORD_W;

   typedef enum logic [3:0] {
      SC_IDLE = 4'b0001,
      SC_MIX  = 4'b0010,
      SC_MUL  = 4'b0100,
      SC_ADD  = 4'b1000
   } sc_state_type;

   sc_state_type       sc_ff, sc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               take;
   xsa_pkg::word_type  acc_ff [LN];
   xsa_pkg::word_type  sum    [LN];
   xsa_pkg::word_type  mix_ff [LN];
   xsa_pkg::word_type  mlo_ff [LN];
   logic [HW-1:0]      mhi_ff [LN];
   xsa_pkg::word_type  out_ff [LN];

   assign take = ctl.valid && adv;

   always_comb begin
      case (sc_ff)
         SC_IDLE: sc_in = (take && ctl.scramble) ? SC_MIX : SC_IDLE;
         SC_MIX:  sc_in = SC_MUL;
         SC_MUL:  sc_in = SC_ADD;
         SC_ADD:  sc_in = SC_IDLE;
         default: sc_in = SC_IDLE;
      endcase
   end

   assign rsp_valid_in = (take && ctl.final_item) || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      for (int i = 0; i < LN; i++) begin
         sum[i] = acc_ff[i] + inc[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= SC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         sc_ff        <= sc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LN; i++) begin
            acc_ff[i] <= xsa_pkg::ACC_INIT[i];
         end
      end else if (sc_ff == SC_ADD) begin
         for (int i = 0; i < LN; i++) begin
            acc_ff[i] <= mlo_ff[i] + {mhi_ff[i], {HW{1'b0}}};
         end
      end else if (take) begin
         for (int i = 0; i < LN; i++) begin
            acc_ff[i] <= ctl.final_item ? xsa_pkg::ACC_INIT[i] : sum[i];
         end
      end
   end

   // scramble: xor-shift and secret, then 64x32 product as two 32x32 halves
   always_ff @(posedge clock) begin
      for (int i = 0; i < LN; i++) begin
         if (sc_ff == SC_MIX) begin
            mix_ff[i] <= acc_ff[i] ^ (acc_ff[i] >> xsa_pkg::SHIFT_MIX) ^ scr_secret[i];
         end
         if (sc_ff == SC_MUL) begin
            mlo_ff[i] <= WW'(mix_ff[i][HW-1:0]) * WW'(xsa_pkg::PRIME32_1);
            mhi_ff[i] <= mix_ff[i][WW-1:HW] * xsa_pkg::PRIME32_1;
         end
         if (take && ctl.final_item) begin
            out_ff[i] <= sum[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < LN; i++) begin
         acc_out[i] = out_ff[i];
      end
   end

endmodule

// ----- src/xxh3_stripe_accumulator_core.sv -----
// XXH3-64 long-input accumulator, one 64-byte stripe per word.
// req_chan: valid/ready word carrying mode, secret_index and eight lane words.
//   Load-secret words write lane_word_0 into the secret at secret_index.
//   Stripe words run through eight lanes (secret xor, 32x32 product, sum),
//   and a merge stage adds them into the accumulators.
// rsp_chan: valid/ready word with the eight accumulators; only a final
//   stripe produces one, once it has passed the lane stages and the merge stage.
// Throughput: one word per cycle while ready is high. After the last
//   stripe of each block of (SECRET_BYTES-64)/8 stripes, ready stays low
//   until it reaches the merge stage; the scramble pass (xor-shift, then the
//   PRIME32_1 multiply on the accumulators) runs; the next stripe must see it.
// Reset: accumulators back to their initial primes, stripe count zero,
//   pipeline and result register empty. Secret contents are undefined
//   until loaded.
// Receiver stall: the result register holds its word. A further final
//   stripe waits in the merge stage, holding the pipeline and ready low,
//   until the result is taken.
module xxh3_stripe_accumulator_core #(
   parameter int SECRET_BYTES = xsa_pkg::SECRET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   xsa_req_if.sink     req_chan,
   xsa_rsp_if.source   rsp_chan
);

   localparam int LN            = xsa_pkg::LANES;
   localparam int IW            = xsa_pkg::IDX_W;
   localparam int NWORDS        = SECRET_BYTES / xsa_pkg::WORD_BYTES;
   localparam int BLOCK_STRIPES =
      (SECRET_BYTES - xsa_pkg::STRIPE_BYTES) / xsa_pkg::WORD_BYTES;
   localparam int SIB_W         = $clog2(BLOCK_STRIPES);
   localparam int TAIL_BASE     = SECRET_BYTES - xsa_pkg::TAIL_BYTES;
   localparam logic [SIB_W-1:0] SIB_LAST = SIB_W'(BLOCK_STRIPES - 1);

   logic [SIB_W-1:0]   sib_ff, sib_in;
   logic               busy_ff, busy_in;
   xsa_pkg::ctl_type   ctl_a_ff, ctl_a_in, ctl_b_ff, ctl_c_ff;
   logic               accept, adv, load_word, wr_en, rsp_valid;
   logic [7:0]         tail_ff   [xsa_pkg::TAIL_BYTES];
   xsa_pkg::word_type  lane_word [LN];
   xsa_pkg::word_type  final_sec [LN];
   xsa_pkg::word_type  scr_sec   [LN];
   xsa_pkg::word_type  inc       [LN];
   xsa_pkg::word_type  acc_out   [LN];
   logic [IW-1:0]      rd_addr   [LN];

   assign adv = !(ctl_c_ff.valid && ctl_c_ff.final_item && rsp_valid && !rsp_chan.ready);
   assign req_chan.ready = adv && !busy_ff;
   assign accept    = req_chan.valid && req_chan.ready;
   assign load_word = accept && (req_chan.mode == xsa_pkg::MODE_LOAD);
   assign wr_en     = load_word && ({1'b0, req_chan.secret_index} < (IW + 1)'(NWORDS));

   always_comb begin
      ctl_a_in = '0;
      sib_in   = sib_ff;
      busy_in  = busy_ff;
      if (accept) begin
         case (req_chan.mode)
            xsa_pkg::MODE_STRIPE: begin
               ctl_a_in.valid    = 1'b1;
               ctl_a_in.scramble = (sib_ff == SIB_LAST);
               sib_in            = (sib_ff == SIB_LAST) ? '0 : sib_ff + SIB_W'(1);
               busy_in           = (sib_ff == SIB_LAST);
            end
            xsa_pkg::MODE_FINAL: begin
               ctl_a_in.valid      = 1'b1;
               ctl_a_in.final_item = 1'b1;
               sib_in              = '0;
            end
            default: ctl_a_in = '0;
         endcase
      end
      // block's last stripe leaves the merge stage: scramble finishes before
      // anything accepted now can reach it
      if (ctl_c_ff.valid && ctl_c_ff.scramble && adv) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sib_ff   <= '0;
         busy_ff  <= 1'b0;
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         sib_ff  <= sib_in;
         busy_ff <= busy_in;
         if (adv) begin
            ctl_a_ff <= ctl_a_in;
            ctl_b_ff <= ctl_a_ff;
            ctl_c_ff <= ctl_b_ff;
         end
      end
   end

   // top 71 secret bytes in flops: final-stripe and scramble secrets
   always_ff @(posedge clock) begin
      if (load_word) begin
         for (int j = 0; j < xsa_pkg::TAIL_BYTES; j++) begin
            if (((TAIL_BASE + j) / xsa_pkg::WORD_BYTES + 1) * xsa_pkg::WORD_BYTES
                   <= SECRET_BYTES
                && req_chan.secret_index == IW'((TAIL_BASE + j) / xsa_pkg::WORD_BYTES)) begin
               tail_ff[j] <= req_chan.lane_word_0[8 * ((TAIL_BASE + j) % xsa_pkg::WORD_BYTES) +: 8];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LN; i++) begin
         for (int b = 0; b < xsa_pkg::WORD_BYTES; b++) begin
            final_sec[i][8 * b +: 8] = tail_ff[xsa_pkg::WORD_BYTES * i + b];
            scr_sec[i][8 * b +: 8]   =
               tail_ff[xsa_pkg::LASTACC_START + xsa_pkg::WORD_BYTES * i + b];
         end
         rd_addr[i] = IW'(sib_ff) + IW'(i);
      end
   end

   assign lane_word[0] = req_chan.lane_word_0;
   assign lane_word[1] = req_chan.lane_word_1;
   assign lane_word[2] = req_chan.lane_word_2;
   assign lane_word[3] = req_chan.lane_word_3;
   assign lane_word[4] = req_chan.lane_word_4;
   assign lane_word[5] = req_chan.lane_word_5;
   assign lane_word[6] = req_chan.lane_word_6;
   assign lane_word[7] = req_chan.lane_word_7;

   for (genvar i = 0; i < LN; i++) begin : g_lane
      xsa_lane #(
         .SECRET_BYTES (SECRET_BYTES)
      ) u_lane (
         .clock        (clock),
         .adv          (adv),
         .wr_en        (wr_en),
         .wr_addr      (req_chan.secret_index),
         .wr_data      (req_chan.lane_word_0),
         .rd_addr      (rd_addr[i]),
         .final_sel    (ctl_a_ff.final_item),
         .data_own     (lane_word[i]),
         .data_mate    (lane_word[i ^ 1]),
         .final_secret (final_sec[i]),
         .inc          (inc[i])
      );
   end

   xsa_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .ctl        (ctl_c_ff),
      .inc        (inc),
      .scr_secret (scr_sec),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .acc_out    (acc_out)
   );

   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.acc_out_0 = acc_out[0];
   assign rsp_chan.acc_out_1 = acc_out[1];
   assign rsp_chan.acc_out_2 = acc_out[2];
   assign rsp_chan.acc_out_3 = acc_out[3];
   assign rsp_chan.acc_out_4 = acc_out[4];
   assign rsp_chan.acc_out_5 = acc_out[5];
   assign rsp_chan.acc_out_6 = acc_out[6];
   assign rsp_chan.acc_out_7 = acc_out[7];

endmodule

// ----- src/xsa_checker.sv -----
module xsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [xsa_pkg::MODE_W-1:0]        req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [xsa_pkg::LANES*xsa_pkg::WORD_W-1:0] rsp_word
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // ready only drops after an accepted stripe (in the design, one closing a block) or behind a held result
   a_ready_drop_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |->
         $past(req_valid && req_ready && req_mode == xsa_pkg::MODE_STRIPE)
         || (rsp_valid && !rsp_ready))
      else $error("ready dropped without cause");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("result changed while stalled");

endmodule

bind xxh3_stripe_accumulator_core xsa_checker u_xsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  ({rsp_chan.acc_out_7, rsp_chan.acc_out_6, rsp_chan.acc_out_5,
                rsp_chan.acc_out_4, rsp_chan.acc_out_3, rsp_chan.acc_out_2,
                rsp_chan.acc_out_1, rsp_chan.acc_out_0})
);

// ----- verif/xxh3_stripe_accumulator_checker.sv -----
module xxh3_stripe_accumulator_checker (
   input  logic clock,
   input  logic reset,
   xsa_req_if   req_chan,
   xsa_rsp_if   rsp_chan,
   output int   mismatches,
   output int   outstanding,
   output int   results_checked,
   output int   scrambles
);
   timeunit 1ns;
   timeprecision 1ps;

   import xsa_pkg::*;

   localparam int SECRET_BYTES      = SECRET_BYTES_DEF;
   localparam int STRIPES_PER_BLOCK = (SECRET_BYTES - STRIPE_BYTES) / WORD_BYTES;
   localparam int SCRAMBLE_BASE     = SECRET_BYTES - STRIPE_BYTES;
   localparam int FINAL_OFFSET      = SECRET_BYTES - TAIL_BYTES;
   localparam int REPORT_LIMIT      = 10;
   localparam word_type LOW_MASK    = 64'h0000_0000_FFFF_FFFF;

   typedef logic [LANES*WORD_W-1:0] acc_vec_type;

   word_type    acc [LANES];
   logic [7:0]  secret [SECRET_BYTES];
   int          stripe_count;
   acc_vec_type pending_accs [$];

   function automatic word_type secret_word_at(input int off);
      word_type w;
      w = '0;
      for (int b = 0; b < WORD_BYTES; b++)
         if (off + b < SECRET_BYTES) w[8*b +: 8] = secret[off + b];
      return w;
   endfunction

   function automatic void absorb_stripe(input word_type lanes [LANES], input int sec_off);
      word_type next_acc [LANES];
      word_type k;
      for (int i = 0; i < LANES; i++) begin
         k = lanes[i] ^ secret_word_at(sec_off + WORD_BYTES * i);
         next_acc[i] = acc[i] + lanes[i ^ 1] + (k & LOW_MASK) * (k >> HALF_W);
      end
      acc = next_acc;
   endfunction

   function automatic void scramble_accs();
      word_type a;
      for (int i = 0; i < LANES; i++) begin
         a = acc[i] ^ (acc[i] >> SHIFT_MIX);
         a = a ^ secret_word_at(SCRAMBLE_BASE + WORD_BYTES * i);
         acc[i] = a * {{HALF_W{1'b0}}, PRIME32_1};
      end
   endfunction

   always @(posedge clock) begin : watch
      word_type    lanes [LANES];
      word_type    got [LANES];
      acc_vec_type want;
      int          base;
      if (reset) begin
         acc          = ACC_INIT;
         stripe_count = 0;
         pending_accs.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got[0] = rsp_chan.acc_out_0;
            got[1] = rsp_chan.acc_out_1;
            got[2] = rsp_chan.acc_out_2;
            got[3] = rsp_chan.acc_out_3;
            got[4] = rsp_chan.acc_out_4;
            got[5] = rsp_chan.acc_out_5;
            got[6] = rsp_chan.acc_out_6;
            got[7] = rsp_chan.acc_out_7;
            if (pending_accs.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%t: result word with none expected, acc_out_0 %h", $realtime, got[0]);
               mismatches++;
            end else begin
               want = pending_accs.pop_front();
               for (int i = 0; i < LANES; i++) begin
                  if (got[i] !== want[WORD_W*i +: WORD_W]) begin
                     if (mismatches < REPORT_LIMIT)
                        $display("%t: result %0d acc_out_%0d expected %h got %h", $realtime,
                                 results_checked, i, want[WORD_W*i +: WORD_W], got[i]);
                     mismatches++;
                  end
               end
               results_checked++;
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            lanes[0] = req_chan.lane_word_0;
            lanes[1] = req_chan.lane_word_1;
            lanes[2] = req_chan.lane_word_2;
            lanes[3] = req_chan.lane_word_3;
            lanes[4] = req_chan.lane_word_4;
            lanes[5] = req_chan.lane_word_5;
            lanes[6] = req_chan.lane_word_6;
            lanes[7] = req_chan.lane_word_7;
            case (req_chan.mode)
               MODE_LOAD: begin
                  base = int'(req_chan.secret_index) * WORD_BYTES;
                  if (base + WORD_BYTES <= SECRET_BYTES)
                     for (int b = 0; b < WORD_BYTES; b++)
                        secret[base + b] = lanes[0][8*b +: 8];
               end
               MODE_STRIPE: begin
                  absorb_stripe(lanes, stripe_count * WORD_BYTES);
                  stripe_count++;
                  if (stripe_count >= STRIPES_PER_BLOCK) begin
                     scramble_accs();
                     scrambles++;
                     stripe_count = 0;
                  end
               end
               MODE_FINAL: begin
                  absorb_stripe(lanes, FINAL_OFFSET);
                  for (int i = 0; i < LANES; i++)
                     want[WORD_W*i +: WORD_W] = acc[i];
                  pending_accs.push_back(want);
                  acc          = ACC_INIT;
                  stripe_count = 0;
               end
               default: ;
            endcase
         end
      end
      outstanding = pending_accs.size();
   end

endmodule

// ----- verif/xxh3_stripe_accumulator_core_tb.sv -----
module xxh3_stripe_accumulator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xsa_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 1000;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int KEY_WORDS    = SECRET_BYTES_DEF / WORD_BYTES;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   gaps_on = 1'b1;
   int   hold_requests = 0;
   int   mismatches, outstanding, results_checked, scrambles;
   int   stripes_sent = 0, finals_sent = 0, loads_sent = 0, ignored_sent = 0;
   word_type key_words [KEY_WORDS];

   xsa_req_if req_chan ();
   xsa_rsp_if rsp_chan ();

   xxh3_stripe_accumulator_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   xxh3_stripe_accumulator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .scrambles       (scrambles)
   );

   always #4 clock = ~clock;

   function automatic word_type rand_lane();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2:       return {32'hFFFF_FFFF, 32'($urandom)};
         3:       return {32'($urandom), 32'h0000_0000};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] index,
                            input word_type lanes [LANES]);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode;
      req_chan.secret_index <= index;
      req_chan.lane_word_0  <= lanes[0];
      req_chan.lane_word_1  <= lanes[1];
      req_chan.lane_word_2  <= lanes[2];
      req_chan.lane_word_3  <= lanes[3];
      req_chan.lane_word_4  <= lanes[4];
      req_chan.lane_word_5  <= lanes[5];
      req_chan.lane_word_6  <= lanes[6];
      req_chan.lane_word_7  <= lanes[7];
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      case (mode)
         MODE_LOAD:   if (index < KEY_WORDS) loads_sent++; else ignored_sent++;
         MODE_STRIPE: stripes_sent++;
         MODE_FINAL:  finals_sent++;
         default:     ignored_sent++;
      endcase
   endtask

   task automatic send_message(input int n_stripes);
      word_type lanes [LANES];
      repeat (n_stripes) begin
         foreach (lanes[i]) lanes[i] = rand_lane();
         send_word(MODE_STRIPE, IDX_W'($urandom), lanes);
      end
      foreach (lanes[i]) lanes[i] = rand_lane();
      send_word(MODE_FINAL, IDX_W'($urandom), lanes);
   endtask

   // receiver: random short stalls, one long hold on request
   initial begin : sink_side
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      word_type lanes [LANES];
      int       r;
      int       n;
      req_chan.valid        = 1'b0;
      req_chan.mode         = MODE_LOAD;
      req_chan.secret_index = '0;
      req_chan.lane_word_0  = '0;
      req_chan.lane_word_1  = '0;
      req_chan.lane_word_2  = '0;
      req_chan.lane_word_3  = '0;
      req_chan.lane_word_4  = '0;
      req_chan.lane_word_5  = '0;
      req_chan.lane_word_6  = '0;
      req_chan.lane_word_7  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole secret before any stripe reads it
      for (int w = 0; w < KEY_WORDS; w++) begin
         key_words[w] = (w == 0) ? '1 : (w == 1) ? '0 : rand_lane();
         foreach (lanes[i]) lanes[i] = rand_lane();
         lanes[0] = key_words[w];
         send_word(MODE_LOAD, IDX_W'(w), lanes);
      end

      // loads past the end of the secret, unused mode: no effect
      foreach (lanes[i]) lanes[i] = '1;
      send_word(MODE_LOAD, IDX_W'(KEY_WORDS), lanes);
      send_word(MODE_LOAD, '1, lanes);
      send_word(MODE_UNUSED, '1, lanes);

      // final stripe with no body
      foreach (lanes[i]) lanes[i] = '0;
      send_word(MODE_FINAL, '0, lanes);

      // key product zero, then all ones in both halves
      foreach (lanes[i]) lanes[i] = key_words[i];
      send_word(MODE_STRIPE, '0, lanes);
      foreach (lanes[i]) lanes[i] = ~key_words[i + 1];
      send_word(MODE_STRIPE, '0, lanes);
      foreach (lanes[i]) lanes[i] = '1;
      send_word(MODE_FINAL, '1, lanes);

      // long result stall while short messages keep coming
      hold_requests++;
      repeat (6) send_message($urandom_range(0, 2));

      while (stripes_sent + finals_sent + loads_sent < ITEM_TARGET) begin
         if (stripes_sent + finals_sent + loads_sent >= ITEM_TARGET - CALM_TAIL)
            gaps_on = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 8) begin
            foreach (lanes[i]) lanes[i] = rand_lane();
            send_word(MODE_LOAD, IDX_W'($urandom_range(0, KEY_WORDS - 1)), lanes);
         end else if (r < 12) begin
            foreach (lanes[i]) lanes[i] = rand_lane();
            if (r < 10)
               send_word(MODE_UNUSED, IDX_W'($urandom), lanes);
            else
               send_word(MODE_LOAD, IDX_W'($urandom_range(KEY_WORDS, 31)), lanes);
         end else begin
            r = $urandom_range(0, 19);
            if (r < 3)
               n = 0;
            else if (r < 6)
               n = 16 * $urandom_range(1, 2);
            else if (r < 8)
               n = ($urandom_range(0, 1) == 0) ? 15 : 17;
            else
               n = $urandom_range(1, 40);
            send_message(n);
         end
      end
      req_chan.valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("coverage: %0d stripes, %0d final stripes, %0d secret loads, %0d ignored words",
               stripes_sent, finals_sent, loads_sent, ignored_sent);
      $display("coverage: %0d accumulator results checked, %0d block scrambles, %0d mismatches",
               results_checked, scrambles, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
